[sv/ets_pkg.sv]
`timescale 1ns / 1ps

package ets_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   // wide enough for frame numbers, lengths and the depth itself (up to 511)
   localparam int LEN_W       = 9;
   localparam int FRAME_W     = 7;
   localparam int ENTRY_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 7;

   // action codes of an input word
   typedef enum logic [2:0] {
      ACT_TICK      = 3'd0,
      ACT_WRITE     = 3'd1,
      ACT_LOOP_NOTE = 3'd2,
      ACT_ONCE_NOTE = 3'd3,
      ACT_RELEASE   = 3'd4,
      ACT_PERC      = 3'd5,
      ACT_SILENCE   = 3'd6
   } action_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENVELOPE_LENGTH  = 3'd0,
      CSR_SUSTAIN_START    = 3'd1,
      CSR_RELEASE_START    = 3'd2,
      CSR_DIST_LOW_NOTES   = 3'd3,
      CSR_DIST_HIGH_NOTES  = 3'd4
   } csr_index_type;

   // play mode, one-hot
   typedef enum logic [3:0] {
      MODE_SILENT = 4'b0001,
      MODE_LOOP   = 4'b0010,
      MODE_ONCE   = 4'b0100,
      MODE_PERC   = 4'b1000
   } play_mode_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [5:0]        note;
      logic [5:0]        entry_index;
      logic signed [7:0] entry_frequency;
      logic [3:0]        entry_volume;
      logic [3:0]        entry_distortion;
   } req_word_type;

   typedef struct packed {
      logic [3:0] distortion_out;
      logic [7:0] frequency_out;
      logic [3:0] volume_out;
   } rsp_word_type;

   // what the control stage hands to the result stage for one accepted word
   typedef struct packed {
      logic       result;     // word gives a result
      logic       silent;     // result is all zeros
      logic       perc;       // take distortion and frequency from the frame
      logic [3:0] note_dist;  // note distortion
      logic [4:0] fold;       // note folded to 0..31
   } issue_type;

endpackage

[sv/ets_table_mem.sv]
`timescale 1ns / 1ps

module ets_table_mem (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [ets_pkg::IDX_W-1:0]         wr_addr,
   input  logic [ets_pkg::ENTRY_W-1:0]       wr_data,
   input  logic                              rd_en,
   input  logic [ets_pkg::IDX_W-1:0]         rd_addr,
   output logic [ets_pkg::ENTRY_W-1:0]       rd_data
);

   logic [ets_pkg::ENTRY_W-1:0] table_mem [ets_pkg::TABLE_DEPTH];
   logic [ets_pkg::ENTRY_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next enabled read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ets_ctrl.sv]
`timescale 1ns / 1ps

module ets_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  ets_pkg::req_word_type               req_word,
   input  logic                                csr_write,
   input  logic [ets_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ets_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                mem_wr_en,
   output logic [ets_pkg::IDX_W-1:0]           mem_wr_addr,
   output logic [ets_pkg::ENTRY_W-1:0]         mem_wr_data,
   output logic                                mem_rd_en,
   output logic [ets_pkg::IDX_W-1:0]           mem_rd_addr,
   output ets_pkg::issue_type                  issue
);

   logic [6:0] env_len_ff;
   logic [5:0] sustain_ff;
   logic [6:0] release_ff;
   logic [3:0] dist_low_ff;
   logic [3:0] dist_high_ff;

   ets_pkg::play_mode_type             mode_ff, mode_in;
   logic [ets_pkg::FRAME_W-1:0]        frame_ff, frame_in;
   logic [5:0]                         note_ff, note_in;

   logic [ets_pkg::LEN_W-1:0]          len_raw;
   logic [ets_pkg::LEN_W-1:0]          len_eff;
   logic [ets_pkg::LEN_W-1:0]          frame_ext;
   logic [ets_pkg::LEN_W-1:0]          eidx_ext;
   logic [ets_pkg::FRAME_W-1:0]        frame_inc;
   logic                               in_range;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         env_len_ff   <= 7'd1;
         sustain_ff   <= 6'd0;
         release_ff   <= 7'd1;
         dist_low_ff  <= 4'd0;
         dist_high_ff <= 4'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            ets_pkg::CSR_ENVELOPE_LENGTH: env_len_ff   <= csr_data[6:0];
            ets_pkg::CSR_SUSTAIN_START:   sustain_ff   <= csr_data[5:0];
            ets_pkg::CSR_RELEASE_START:   release_ff   <= csr_data[6:0];
            ets_pkg::CSR_DIST_LOW_NOTES:  dist_low_ff  <= csr_data[3:0];
            ets_pkg::CSR_DIST_HIGH_NOTES: dist_high_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // length capped at the table depth
   assign len_raw   = ets_pkg::LEN_W'(env_len_ff);
   assign len_eff   = (len_raw > ets_pkg::LEN_W'(ets_pkg::TABLE_DEPTH)) ?
                      ets_pkg::LEN_W'(ets_pkg::TABLE_DEPTH) : len_raw;
   assign frame_ext = ets_pkg::LEN_W'(frame_ff);
   assign eidx_ext  = ets_pkg::LEN_W'(req_word.entry_index);
   assign frame_inc = frame_ff + 7'd1;
   assign in_range  = frame_ext < len_eff;

   // table write and frame read
   assign mem_wr_en   = accept && (req_word.action == ets_pkg::ACT_WRITE) &&
                        (eidx_ext < ets_pkg::LEN_W'(ets_pkg::TABLE_DEPTH));
   assign mem_wr_addr = eidx_ext[ets_pkg::IDX_W-1:0];
   assign mem_wr_data = {req_word.entry_distortion, req_word.entry_volume,
                         req_word.entry_frequency};
   assign mem_rd_addr = frame_ext[ets_pkg::IDX_W-1:0];

   // next play state and the result hand-off
   always_comb begin
      mode_in     = mode_ff;
      frame_in    = frame_ff;
      note_in     = note_ff;
      mem_rd_en   = 1'b0;
      issue.result    = 1'b0;
      issue.silent    = (mode_ff == ets_pkg::MODE_SILENT);
      issue.perc      = (mode_ff == ets_pkg::MODE_PERC);
      issue.note_dist = note_ff[5] ? dist_high_ff : dist_low_ff;
      issue.fold      = note_ff[4:0];
      if (accept) begin
         unique case (req_word.action)
            ets_pkg::ACT_TICK: begin
               if (mode_ff == ets_pkg::MODE_SILENT) begin
                  issue.result = 1'b1;
               end else if (!in_range) begin
                  mode_in = ets_pkg::MODE_SILENT;
               end else begin
                  issue.result = 1'b1;
                  mem_rd_en    = 1'b1;
                  frame_in     = frame_inc;
                  if (mode_ff != ets_pkg::MODE_PERC) begin
                     priority if (mode_ff != ets_pkg::MODE_ONCE && frame_inc == release_ff) begin
                        frame_in = {1'b0, sustain_ff};
                     end else if (ets_pkg::LEN_W'(frame_inc) == len_eff) begin
                        mode_in = ets_pkg::MODE_SILENT;
                     end else begin
                        // carry on to the next frame
                        frame_in = frame_inc;
                     end
                  end
               end
            end
            ets_pkg::ACT_LOOP_NOTE, ets_pkg::ACT_ONCE_NOTE: begin
               note_in  = req_word.note;
               frame_in = '0;
               mode_in  = (req_word.action == ets_pkg::ACT_LOOP_NOTE) ?
                          ets_pkg::MODE_LOOP : ets_pkg::MODE_ONCE;
            end
            ets_pkg::ACT_RELEASE: begin
               if (mode_ff == ets_pkg::MODE_LOOP || mode_ff == ets_pkg::MODE_ONCE) begin
                  frame_in = release_ff;
               end
            end
            ets_pkg::ACT_PERC: begin
               frame_in = '0;
               mode_in  = ets_pkg::MODE_PERC;
            end
            ets_pkg::ACT_SILENCE: begin
               mode_in = ets_pkg::MODE_SILENT;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ets_pkg::MODE_SILENT;
         frame_ff <= '0;
         note_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         frame_ff <= frame_in;
         note_ff  <= note_in;
      end
   end

endmodule

[sv/ets_result.sv]
`timescale 1ns / 1ps

module ets_result (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  ets_pkg::issue_type             issue,
   input  logic [ets_pkg::ENTRY_W-1:0]    rd_data,
   output logic                           s1_free,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ets_pkg::rsp_word_type          rsp_word
);

   logic                    s1_valid_ff, s1_valid_in;
   ets_pkg::issue_type      s1_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   ets_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;
   logic                    advance;

   // read stage moves on when the output register is empty or being taken
   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_free = !s1_valid_ff || !rsp_valid_ff || rsp_ready;

   always_comb begin
      priority if (accept) begin
         s1_valid_in = issue.result;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      priority if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // result word from the frame just read
   always_comb begin
      rsp_word_in.volume_out = rd_data[11:8];
      if (s1_ff.perc) begin
         rsp_word_in.distortion_out = rd_data[15:12];
         rsp_word_in.frequency_out  = rd_data[7:0];
      end else begin
         rsp_word_in.distortion_out = s1_ff.note_dist;
         rsp_word_in.frequency_out  = {3'b000, s1_ff.fold} + rd_data[7:0];
      end
      if (s1_ff.silent) begin
         rsp_word_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= issue;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[sv/envelope_table_sequencer_unit.sv]
`timescale 1ns / 1ps

// Envelope table sequencer: plays one voice frame by frame from a 64-entry
// table held in a synchronous RAM. A new word can follow an accepted one in
// the next cycle while the result stage is free or being drained. A tick
// gives its distortion, frequency and volume word on rsp_ via the table read
// register and the output register (a tick past the end gives none); other
// actions give no result. Only output back-pressure stalls req_ready, since
// the read stage then holds its RAM data. The table has no reset: frames
// must be written before a note or percussion sound reaches them. The user
// must write configuration registers while the block is idle; not enforced.
module envelope_table_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ets_pkg::req_word_type             req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ets_pkg::rsp_word_type             rsp_word,
   input  logic                              csr_write,
   input  logic [ets_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ets_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic                            accept;
   logic                            s1_free;
   logic                            mem_wr_en;
   logic [ets_pkg::IDX_W-1:0]       mem_wr_addr;
   logic [ets_pkg::ENTRY_W-1:0]     mem_wr_data;
   logic                            mem_rd_en;
   logic [ets_pkg::IDX_W-1:0]       mem_rd_addr;
   logic [ets_pkg::ENTRY_W-1:0]     mem_rd_data;
   ets_pkg::issue_type              issue;

   assign req_ready = s1_free;
   assign accept    = req_valid && s1_free;

   ets_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_word    (req_word),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .issue       (issue)
   );

   ets_table_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ets_result u_result (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .issue     (issue),
      .rd_data   (mem_rd_data),
      .s1_free   (s1_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

[sv/ets_checker.sv]
`timescale 1ns / 1ps

module ets_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  ets_pkg::req_word_type             req_word,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  ets_pkg::rsp_word_type             rsp_word
);

   logic acc;
   assign acc = req_valid && req_ready;

   // output register empty straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result changed");

   // input is held back only by output back-pressure
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // a tick straight after silence gives a zero word if the output is ready to take it
   a_silent_tick: assert property (@(posedge clock) disable iff (reset)
      acc && req_word.action == ets_pkg::ACT_SILENCE
      ##1 acc && req_word.action == ets_pkg::ACT_TICK
      ##1 rsp_ready
      |=> rsp_valid && rsp_word == '0)
      else $error("silent tick gave a wrong word");

endmodule

bind envelope_table_sequencer_unit ets_checker u_ets_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

[verif/envelope_voice_checker.sv]
`timescale 1ns / 1ps

// Watches the request, result and register ports of the envelope sequencer,
// keeps its own copy of the voice state and checks every result word in order.
module envelope_voice_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  ets_pkg::req_word_type          req_word,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  ets_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_write,
   input  logic [ets_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ets_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             pending_words,
   output int                             checked_words,
   output int                             error_count
);
   import ets_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // one table frame as the voice sees it
   typedef struct packed {
      logic [3:0] distortion;
      logic [3:0] vol;
      logic [7:0] freq;
   } frame_type;

   // register copies
   logic [6:0]    length_cfg;
   logic [5:0]    sustain_cfg;
   logic [6:0]    release_cfg;
   logic [3:0]    dist_low_cfg;
   logic [3:0]    dist_high_cfg;

   // voice state
   play_mode_type voice_mode;
   logic [6:0]    frame_pos;
   logic [5:0]    held_note;
   frame_type     frame_store [TABLE_DEPTH];

   // result words still owed by the block, oldest first
   rsp_word_type  owed_words [$];

   // apply one accepted word to the voice, queueing the result word it gives
   task automatic play_word(input req_word_type w);
      frame_type    fr;
      rsp_word_type res;
      int           eff_len;
      eff_len = (int'(length_cfg) > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_cfg);
      case (w.action)
         ACT_WRITE: begin
            if (int'(w.entry_index) < TABLE_DEPTH)
               frame_store[w.entry_index] = {w.entry_distortion, w.entry_volume,
                                             w.entry_frequency};
         end
         ACT_LOOP_NOTE, ACT_ONCE_NOTE: begin
            held_note = w.note;
            frame_pos = '0;
            if (w.action == ACT_LOOP_NOTE)
               voice_mode = MODE_LOOP;
            else
               voice_mode = MODE_ONCE;
         end
         ACT_RELEASE: begin
            // only a sounding note jumps to its release frames
            if (voice_mode == MODE_LOOP || voice_mode == MODE_ONCE)
               frame_pos = release_cfg;
         end
         ACT_PERC: begin
            frame_pos  = '0;
            voice_mode = MODE_PERC;
         end
         ACT_SILENCE: voice_mode = MODE_SILENT;
         ACT_TICK: begin
            if (voice_mode == MODE_SILENT) begin
               res = '0;
               owed_words.push_back(res);
            end else if (int'(frame_pos) >= eff_len) begin
               // ran off the end: stop quietly, no word
               voice_mode = MODE_SILENT;
            end else begin
               fr = frame_store[frame_pos[IDX_W-1:0]];
               res.volume_out = fr.vol;
               if (voice_mode == MODE_PERC) begin
                  res.distortion_out = fr.distortion;
                  res.frequency_out  = fr.freq;
               end else begin
                  res.distortion_out = held_note[5] ? dist_high_cfg : dist_low_cfg;
                  // folded note plus signed offset, wraps at 8 bits
                  res.frequency_out  = fr.freq + {3'b000, held_note[4:0]};
               end
               frame_pos = frame_pos + 7'd1;
               if (voice_mode == MODE_LOOP && frame_pos == release_cfg)
                  frame_pos = {1'b0, sustain_cfg};
               else if (voice_mode != MODE_PERC && int'(frame_pos) == eff_len)
                  voice_mode = MODE_SILENT;
               owed_words.push_back(res);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         length_cfg    = 7'd1;
         sustain_cfg   = '0;
         release_cfg   = 7'd1;
         dist_low_cfg  = '0;
         dist_high_cfg = '0;
         voice_mode    = MODE_SILENT;
         frame_pos     = '0;
         held_note     = '0;
         owed_words.delete();
         checked_words = 0;
         error_count   = 0;
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CSR_ENVELOPE_LENGTH: length_cfg    = csr_data[6:0];
               CSR_SUSTAIN_START:   sustain_cfg   = csr_data[5:0];
               CSR_RELEASE_START:   release_cfg   = csr_data[6:0];
               CSR_DIST_LOW_NOTES:  dist_low_cfg  = csr_data[3:0];
               CSR_DIST_HIGH_NOTES: dist_high_cfg = csr_data[3:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready)
            play_word(req_word);

         // result words against the oldest one owed
         if (rsp_valid && rsp_ready) begin
            if (owed_words.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("%0t: result word with none expected: dist %0d freq %0d vol %0d",
                           $time, rsp_word.distortion_out, rsp_word.frequency_out,
                           rsp_word.volume_out);
               error_count++;
            end else begin
               want = owed_words.pop_front();
               checked_words++;
               if (rsp_word.distortion_out !== want.distortion_out ||
                   rsp_word.frequency_out  !== want.frequency_out  ||
                   rsp_word.volume_out     !== want.volume_out) begin
                  if (error_count < REPORT_LIMIT) begin
                     $display("%0t: mismatch: expected dist %0d freq %0d vol %0d,",
                              $time, want.distortion_out, want.frequency_out,
                              want.volume_out);
                     $display("   got dist %0d freq %0d vol %0d",
                              rsp_word.distortion_out, rsp_word.frequency_out,
                              rsp_word.volume_out);
                  end
                  error_count++;
               end
            end
         end
      end
      pending_words = owed_words.size();
   end

endmodule

[verif/envelope_table_sequencer_unit_test.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the envelope table sequencer; result checking
// lives in envelope_voice_checker.
module envelope_table_sequencer_unit_test;
   import ets_pkg::*;

   localparam int         RANDOM_WORDS  = 1600;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         SETTLE_CYCLES = 4;
   localparam int         DRAIN_CYCLES  = 12;
   localparam int         REQ_W         = $bits(req_word_type);
   localparam logic [2:0] ACT_UNUSED    = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_word_type          rsp_word;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int pending_words;
   int checked_words;
   int error_count;

   // no idling on either side while set
   bit steady_flow;
   // asks the result side for one long hold-off
   bit hold_request;
   bit counting;
   // request word taken at the last rising edge
   bit req_taken;

   int words_sent;
   int tick_words;
   int table_writes;
   int voice_starts;
   int settings_done;
   int random_words;
   int length_now;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) req_taken <= req_valid && req_ready;

   envelope_table_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   envelope_voice_checker voice_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .pending_words (pending_words),
      .checked_words (checked_words),
      .error_count   (error_count)
   );

   // word with random filler in the fields the action does not use
   function automatic req_word_type make_word(logic [2:0] act, int note);
      req_word_type w;
      w        = req_word_type'(REQ_W'($urandom));
      w.action = act;
      w.note   = 6'(note);
      return w;
   endfunction

   // offer one word, after random idle edges unless steady_flow is set, and hold
   // it until taken; returns at the falling edge after the accepting rising edge
   task automatic send_word(input req_word_type w);
      while (!steady_flow && $urandom_range(99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word  = w;
      do @(negedge clock); while (!req_taken);
      words_sent++;
      case (w.action)
         ACT_TICK:  tick_words++;
         ACT_WRITE: table_writes++;
         ACT_LOOP_NOTE, ACT_ONCE_NOTE, ACT_PERC: voice_starts++;
         default: ;
      endcase
      if (counting)
         random_words++;
   endtask

   task automatic send_action(logic [2:0] act, int note);
      send_word(make_word(act, note));
   endtask

   task automatic write_frame(int idx, int freq, int vol, int dist_code);
      req_word_type w;
      w                  = make_word(ACT_WRITE, $urandom);
      w.entry_index      = 6'(idx);
      w.entry_frequency  = 8'(freq);
      w.entry_volume     = 4'(vol);
      w.entry_distortion = 4'(dist_code);
      send_word(w);
   endtask

   // drop valid and let the block run dry
   task automatic settle();
      req_valid = 1'b0;
      wait (pending_words == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, int value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = CSR_DATA_W'(value);
      @(negedge clock);
   endtask

   task automatic program_voice(int len, int sus, int rel, int lo, int hi);
      settle();
      write_register(CSR_ENVELOPE_LENGTH, len);
      write_register(CSR_SUSTAIN_START, sus);
      write_register(CSR_RELEASE_START, rel);
      write_register(CSR_DIST_LOW_NOTES, lo);
      write_register(CSR_DIST_HIGH_NOTES, hi);
      csr_write  = 1'b0;
      length_now = len;
      settings_done++;
   endtask

   // extremes first, then mostly well-formed loops, some odd ones
   task automatic pick_setting(int phase);
      int len;
      int sus;
      int rel;
      case (phase)
         0: program_voice(64, 63, 64, 0, 15);
         1: program_voice(1, 0, 1, 15, 0);
         2: program_voice(64, 0, 1, 15, 15);
         3: program_voice(2, 1, 64, 0, 0);
         default: begin
            len = $urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 64);
            if ($urandom_range(9) < 7) begin
               rel = $urandom_range(1, len);
               sus = $urandom_range(0, rel - 1);
            end else begin
               rel = $urandom_range(1, 64);
               sus = $urandom_range(0, 63);
            end
            program_voice(len, sus, rel, $urandom_range(15), $urandom_range(15));
         end
      endcase
   endtask

   // maybe some frame writes, then a note or percussion hit with ticks, maybe a
   // release and a silence, or now and then a burst of arbitrary words
   task automatic play_sequence();
      int ticks;
      int release_at;
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) begin
         repeat ($urandom_range(1, 6)) send_action(3'($urandom_range(7)), $urandom);
      end else begin
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4))
               write_frame($urandom_range(TABLE_DEPTH - 1), $urandom, $urandom, $urandom);
         roll = $urandom_range(99);
         if (roll < 40)
            send_action(ACT_LOOP_NOTE, $urandom);
         else if (roll < 70)
            send_action(ACT_ONCE_NOTE, $urandom);
         else
            send_action(ACT_PERC, $urandom);
         ticks      = $urandom_range(1, length_now + 4);
         release_at = $urandom_range(1) ? int'($urandom_range(0, ticks)) : -1;
         for (int i = 0; i <= ticks; i++) begin
            if (i == release_at)
               send_action(ACT_RELEASE, $urandom);
            if (i < ticks)
               send_action(ACT_TICK, $urandom);
         end
         if ($urandom_range(2) == 0)
            send_action(ACT_SILENCE, $urandom);
      end
   endtask

   // hold results back while ticks keep coming, so the block backs up
   task automatic fill_and_stall();
      steady_flow = 1'b1;
      send_action(ACT_SILENCE, 0);
      hold_request = 1'b1;
      repeat (40) send_action(ACT_TICK, $urandom);
      settle();
      steady_flow = 1'b0;
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = steady_flow || ($urandom_range(99) >= 7);
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("Run timed out with %0d result words outstanding", pending_words);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int phase;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_word     = '0;
      csr_write    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      steady_flow  = 1'b0;
      hold_request = 1'b0;
      counting     = 1'b0;
      length_now   = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the whole table before anything can play it
      write_frame(0, 8'h7F, 15, 0);
      write_frame(1, 8'hFF, 0, 15);
      write_frame(2, 8'h80, 8, 5);
      write_frame(3, 8'h00, 1, 10);
      for (int i = 4; i < TABLE_DEPTH; i++)
         write_frame(i, $urandom, $urandom, $urandom);

      // directed: four frames, loop back from 3 to 1
      program_voice(4, 1, 3, 5, 10);
      send_action(ACT_TICK, 0);          // silent voice gives zeros
      send_action(ACT_RELEASE, 0);       // release with nothing playing
      send_action(ACT_UNUSED, 0);        // spare action code
      send_action(ACT_LOOP_NOTE, 63);    // high note, offsets wrap
      repeat (5) send_action(ACT_TICK, 0);
      send_action(ACT_RELEASE, 0);
      repeat (2) send_action(ACT_TICK, 0);
      send_action(ACT_ONCE_NOTE, 32);    // one-shot runs out to silence
      repeat (5) send_action(ACT_TICK, 0);
      send_action(ACT_PERC, 0);
      send_action(ACT_RELEASE, 0);       // ignored during percussion
      repeat (5) send_action(ACT_TICK, 0);   // last one is past the end
      send_action(ACT_SILENCE, 0);
      send_action(ACT_TICK, 0);

      // random phases, each under its own register setting
      counting = 1'b1;
      phase    = 0;
      while (random_words < RANDOM_WORDS) begin
         pick_setting(phase);
         if (phase == 2)
            fill_and_stall();
         steady_flow = (phase == 3);
         repeat (12) play_sequence();
         steady_flow = 1'b0;
         phase++;
      end

      // wind down
      req_valid = 1'b0;
      wait (pending_words == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words (%0d ticks, %0d table writes, %0d note or percussion starts)",
               words_sent, tick_words, table_writes, voice_starts);
      $display("under %0d register settings; %0d result words checked, %0d failures",
               settings_done, checked_words, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[envelope_table_sequencer_unit.f]
sv/ets_pkg.sv
sv/ets_table_mem.sv
sv/ets_ctrl.sv
sv/ets_result.sv
sv/envelope_table_sequencer_unit.sv
sv/ets_checker.sv
verif/envelope_voice_checker.sv
verif/envelope_table_sequencer_unit_test.sv
